FILE: hdl/tcfp_pkg.sv
`timescale 1ns / 1ps

package tcfp_pkg;

    // Frame framing bytes.
    localparam logic [7:0] HDR_FIRST  = 8'h24;  // '$'
    localparam logic [7:0] HDR_SECOND = 8'h54;  // 'T'
    localparam logic [7:0] TYPE_R     = 8'h52;  // 'R', channels 0-7
    localparam logic [7:0] TYPE_T     = 8'h54;  // 'T', channels 8-15

    // Default payload length and the fixed field widths.
    localparam int PAYLOAD_BYTES_DEF = 16;
    localparam int CNT_W             = 5;
    localparam int CH_PER_BANK       = 8;

    // Parser phase. Codes 5 to 7 are unused and behave like hunting.
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_TYPE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } t_phase;

endpackage

FILE: hdl/telemetry_channel_frame_parser_top.sv
`timescale 1ns / 1ps

// Telemetry channel frame parser.
//
// Input channel: one received byte per beat on i_rx_byte, qualified by
// i_valid and held off by o_stall. Frames look like '$' 'T' <type> followed
// by PAYLOAD_BYTES payload bytes and one checksum byte (XOR of the payload).
// Output channel: o_valid / i_stall. A frame whose checksum matches produces
// min(PAYLOAD_BYTES/2, 8) beats, one per channel, with the channel index,
// the little-endian 16-bit value and a last flag; a bad frame yields nothing.
//
// Throughput: one input byte per cycle while o_stall is low. The first result
// of a frame follows the drain start, the memory read and the output register,
// then one result per cycle while the receiver takes them.
// The payload lives in a two-slot memory of 16-bit words: one slot fills
// while the other drains. o_stall is high while a checksum byte is due and
// the previous frame still has memory reads to issue.
// Reset (synchronous, active low) returns the parser to hunting, empties the
// output side and drops any frame in progress. The payload memory needs no
// clearing: every word is written within a frame before it is read.
// When the receiver stalls, the output beat and the read stage behind it
// hold; the parser keeps accepting bytes until the next checksum byte.

module telemetry_channel_frame_parser_top
    import tcfp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_channel_index,
    output logic [15:0] o_channel_value,
    output logic        o_last_of_frame
);

    // Channels per frame and the memory geometry that follows from it.
    localparam int NCH       = (PAYLOAD_BYTES / 2 > CH_PER_BANK) ?
                               CH_PER_BANK : PAYLOAD_BYTES / 2;
    localparam int KW        = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int MEM_DEPTH = 2 ** (KW + 1);
    localparam int STORE_LEN = 2 * NCH;

    // Parser state.
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_xor, n_xor;
    logic             r_bank, n_bank;
    logic [7:0]       r_lo_byte;
    logic             r_wr_slot;

    // Payload memory: two slots of 2**KW words, of which NCH are used.
    logic [15:0]      mem [MEM_DEPTH];
    logic             wr_en;
    logic [KW:0]      wr_addr;

    // Drain sequencer.
    logic             r_drain_active;
    logic             r_drain_slot;
    logic             r_drain_bank;
    logic [KW-1:0]    r_drain_k;

    // Read stage and output register.
    logic             r_rd_valid;
    logic [3:0]       r_rd_index;
    logic             r_rd_last;
    logic [15:0]      r_mem_q;
    logic             r_out_valid;
    logic [3:0]       r_out_index;
    logic [15:0]      r_out_value;
    logic             r_out_last;

    logic             in_acc;
    logic             out_free;
    logic             rd_issue;
    logic             cnt_next_wrap;
    logic [CNT_W-1:0] cnt_inc;
    logic             csum_ok;
    logic             drain_start;

    // A checksum byte must wait until the previous frame has issued all reads,
    // because accepting it flips the slots.
    assign o_stall  = (r_phase == PH_CHECK) && r_drain_active;
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign rd_issue = r_drain_active && (!r_rd_valid || out_free);

    assign cnt_inc       = r_count + CNT_W'(1);
    assign cnt_next_wrap = ({1'b0, cnt_inc} >= (CNT_W + 1)'(PAYLOAD_BYTES)) ||
                           (cnt_inc == '0);
    assign csum_ok       = (i_rx_byte == r_xor);

    // Next-state logic of the parser.
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_xor   = r_xor;
        n_bank  = r_bank;
        case (r_phase)
            PH_HDR2: begin
                n_phase = (i_rx_byte == HDR_SECOND) ? PH_TYPE : PH_HUNT;
            end
            PH_TYPE: begin
                n_count = '0;
                n_xor   = '0;
                if (i_rx_byte == TYPE_R || i_rx_byte == TYPE_T) begin
                    n_bank  = (i_rx_byte == TYPE_T);
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                n_xor   = r_xor ^ i_rx_byte;
                n_count = cnt_inc;
                if (cnt_next_wrap) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_HUNT;
                n_count = '0;
                n_xor   = '0;
            end
            default: begin
                n_phase = (i_rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
        endcase
    end

    // Outputs of the parser: memory write and drain start.
    always_comb begin
        wr_en       = 1'b0;
        wr_addr     = {r_wr_slot, r_count[KW:1]};
        drain_start = 1'b0;
        case (r_phase)
            PH_PAYLOAD: begin
                // An odd byte completes a word; the even byte waits in r_lo_byte.
                wr_en = in_acc && r_count[0] &&
                        ({1'b0, r_count} < (CNT_W + 1)'(STORE_LEN));
            end
            PH_CHECK: begin
                drain_start = in_acc && csum_ok;
            end
            default: begin
                wr_en       = 1'b0;
                drain_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_xor     <= '0;
            r_bank    <= 1'b0;
            r_wr_slot <= 1'b0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_xor   <= n_xor;
            r_bank  <= n_bank;
            if (drain_start) begin
                r_wr_slot <= ~r_wr_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && r_phase == PH_PAYLOAD && !r_count[0]) begin
            r_lo_byte <= i_rx_byte;
        end
    end

    // Payload memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= {i_rx_byte, r_lo_byte};
        end
        if (rd_issue) begin
            r_mem_q <= mem[{r_drain_slot, r_drain_k}];
        end
    end

    // Drain sequencer walks the channels of the finished slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_active <= 1'b0;
        end else if (drain_start) begin
            r_drain_active <= 1'b1;
        end else if (rd_issue && r_drain_k == KW'(NCH - 1)) begin
            r_drain_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_start) begin
            r_drain_slot <= r_wr_slot;
            r_drain_bank <= r_bank;
            r_drain_k    <= '0;
        end else if (rd_issue) begin
            r_drain_k <= r_drain_k + KW'(1);
        end
    end

    // Read stage: valid plus the beat's side fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (rd_issue) begin
            r_rd_valid <= 1'b1;
        end else if (out_free) begin
            r_rd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_index <= {r_drain_bank, 3'(r_drain_k)};
            r_rd_last  <= (r_drain_k == KW'(NCH - 1));
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_rd_valid) begin
            r_out_index <= r_rd_index;
            r_out_value <= r_mem_q;
            r_out_last  <= r_rd_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_last_of_frame = r_out_last;

    // The filling slot never collides with the slot being read.
    a_slot_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_drain_active) |-> (r_wr_slot != r_drain_slot))
        else $error("payload write into the slot being drained");

    // A new drain starts only after the previous one issued all reads.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_start |-> !r_drain_active)
        else $error("drain started while another is active");

    // The final beat of a frame carries the last channel position.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_index[2:0] == 3'(NCH - 1)))
        else $error("last flag on the wrong channel");

    // The read stage never drops a beat that the output could not take.
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && !out_free) |=> r_rd_valid)
        else $error("read stage lost a pending beat");

endmodule

FILE: dv/tb_telemetry_channel_frame_parser_top.sv
`timescale 1ns / 1ps

// Testbench for the telemetry channel frame parser.
//
// The sender task offers one byte per beat and runs it through a local parser
// model as soon as the block accepts it. Every channel beat that the model
// produces is queued. A checker process compares each accepted output beat,
// field by field, with the oldest queued channel beat. Both sides idle at
// random, and the receiver can also hold off for a long counted stretch.

module tb_telemetry_channel_frame_parser_top
    import tcfp_pkg::*;
();

    localparam int PB        = PAYLOAD_BYTES_DEF;
    localparam int NCH       = (PB / 2 > CH_PER_BANK) ? CH_PER_BANK : PB / 2;
    localparam int TAIL_CYC  = 20;
    localparam int DRAIN_CYC = 20000;

    // One channel beat as it leaves the block.
    typedef struct packed {
        logic [3:0]  index;
        logic [15:0] value;
        logic        last;
    } t_chan_beat;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_channel_index;
    logic [15:0] o_channel_value;
    logic        o_last_of_frame;

    telemetry_channel_frame_parser_top #(
        .PAYLOAD_BYTES (PB)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_of_frame (o_last_of_frame)
    );

    // Local copy of the parser state.
    t_phase             mdl_phase;
    logic               mdl_bank;
    logic [CNT_W-1:0]   mdl_count;
    logic [7:0]         mdl_xor;
    logic [7:0]         mdl_store [PB];

    // Channel beats still owed by the block, oldest first.
    t_chan_beat         owed_beats [$];

    // Idle rates in percent and the remaining cycles of a long receiver hold.
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 rx_hold_left = 0;
    int                 err_count = 0;

    // Payload of the next frame to send, filled by the test tasks.
    logic [7:0]         frame_buf [PB];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic reset_parser_model();
        mdl_phase = PH_HUNT;
        mdl_bank  = 1'b0;
        mdl_count = '0;
        mdl_xor   = 8'h00;
        for (int i = 0; i < PB; i++) mdl_store[i] = 8'h00;
    endtask

    // Advances the parser model by one accepted byte and queues any channel
    // beats that a matching checksum releases.
    task automatic parse_rx_byte(input logic [7:0] b);
        t_chan_beat beat;
        case (mdl_phase)
            PH_HDR2: begin
                // A second '$' does not restart the header; it drops to hunting.
                mdl_phase = (b == HDR_SECOND) ? PH_TYPE : PH_HUNT;
            end
            PH_TYPE: begin
                if (b == TYPE_R || b == TYPE_T) begin
                    mdl_bank  = (b == TYPE_T);
                    mdl_count = '0;
                    mdl_xor   = 8'h00;
                    mdl_phase = PH_PAYLOAD;
                end else begin
                    mdl_phase = PH_HUNT;
                    mdl_count = '0;
                    mdl_xor   = 8'h00;
                end
            end
            PH_PAYLOAD: begin
                if (mdl_count < PB) mdl_store[mdl_count] = b;
                mdl_xor   = mdl_xor ^ b;
                mdl_count = mdl_count + 1'b1;
                if (mdl_count >= PB || mdl_count == 0) mdl_phase = PH_CHECK;
            end
            PH_CHECK: begin
                if (b == mdl_xor) begin
                    for (int k = 0; k < NCH; k++) begin
                        beat.index = 4'(mdl_bank * CH_PER_BANK + k);
                        beat.value = {mdl_store[2*k+1], mdl_store[2*k]};
                        beat.last  = (k == NCH - 1);
                        owed_beats.push_back(beat);
                    end
                end
                mdl_phase = PH_HUNT;
                mdl_count = '0;
                mdl_xor   = 8'h00;
            end
            default: begin
                mdl_phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
        endcase
    endtask

    // Receiver: a long hold counts down first, otherwise stall at random.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_stall <= 1'b1;
                rx_hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Output checker: every accepted beat must match the oldest owed beat.
    always @(posedge i_clk) begin : chk_out
        t_chan_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_beats.size() == 0) begin
                report_mismatch("unexpected beat, index", o_channel_index, 0);
            end else begin
                want = owed_beats.pop_front();
                if (o_channel_index !== want.index)
                    report_mismatch("channel_index", o_channel_index, want.index);
                if (o_channel_value !== want.value)
                    report_mismatch("channel_value", o_channel_value, want.value);
                if (o_last_of_frame !== want.last)
                    report_mismatch("last_of_frame", o_last_of_frame, want.last);
            end
        end
    end

    // Offers one byte and returns once the block has taken it. The valid line
    // stays high into the next call unless a random gap is taken there.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        parse_rx_byte(b);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Sends '$' 'T' <type>, the payload in frame_buf and the checksum. A
    // nonzero ck_flip spoils the checksum.
    task automatic send_frame(input logic [7:0] type_b, input logic [7:0] ck_flip);
        logic [7:0] ck;
        ck = 8'h00;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(type_b);
        for (int i = 0; i < PB; i++) begin
            send_byte(frame_buf[i]);
            ck = ck ^ frame_buf[i];
        end
        send_byte(ck ^ ck_flip);
    endtask

    task automatic fill_random_payload();
        for (int i = 0; i < PB; i++) frame_buf[i] = 8'($urandom_range(0, 255));
    endtask

    // Stops offering bytes until every owed beat has been seen, with a bound.
    task automatic wait_drained();
        int n;
        n = 0;
        stop_sending();
        while (owed_beats.size() != 0 && n < DRAIN_CYC) begin
            @(posedge i_clk);
            n++;
        end
        if (owed_beats.size() != 0) begin
            report_mismatch("beats never delivered", 0, owed_beats.size());
            owed_beats.delete();
        end
    endtask

    function automatic logic [7:0] pick_bad_type();
        logic [7:0] t;
        do t = 8'($urandom_range(0, 255)); while (t == TYPE_R || t == TYPE_T);
        return t;
    endfunction

    // Good frames in both banks, with an all-one and a mixed payload.
    task automatic test_good_frames();
        for (int i = 0; i < PB; i++) frame_buf[i] = 8'hFF;
        send_frame(TYPE_T, 8'h00);
        for (int i = 0; i < PB; i++) frame_buf[i] = (i % 3 == 0) ? 8'hA5 : 8'(i * 17);
        send_frame(TYPE_R, 8'h00);
    endtask

    // A second '$' in place of 'T' must not restart the header, and a wrong
    // second byte drops the parser back to hunting.
    task automatic test_bad_header();
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(TYPE_R);
        send_byte(HDR_FIRST);
        send_byte(8'h00);
        send_byte(HDR_SECOND);
    endtask

    // An unknown type byte aborts the frame.
    task automatic test_bad_type();
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(8'hFF);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
    endtask

    // A checksum off by one bit, then by all bits: no beats at all.
    task automatic test_bad_checksum();
        fill_random_payload();
        send_frame(TYPE_T, 8'h01);
        fill_random_payload();
        send_frame(TYPE_R, 8'hFF);
    endtask

    // Mostly well-formed frames with random content; the rest is noise,
    // broken headers, unknown types, spoiled checksums and cut-off frames.
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_seq);
        int sel;
        int n;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int s = 0; s < n_seq; s++) begin
            sel = $urandom_range(0, 9);
            fill_random_payload();
            if (sel <= 5) begin
                send_frame($urandom_range(0, 1) ? TYPE_T : TYPE_R, 8'h00);
            end else if (sel == 6) begin
                send_frame($urandom_range(0, 1) ? TYPE_T : TYPE_R,
                           8'($urandom_range(1, 255)));
            end else if (sel == 7) begin
                send_byte(HDR_FIRST);
                if ($urandom_range(0, 1)) begin
                    send_byte(8'($urandom_range(0, 255)));
                end else begin
                    send_byte(HDR_SECOND);
                    send_byte(pick_bad_type());
                end
            end else if (sel == 8) begin
                // Cut-off frame: whatever follows lands in its payload.
                send_byte(HDR_FIRST);
                send_byte(HDR_SECOND);
                send_byte(TYPE_R);
                n = $urandom_range(1, PB - 1);
                for (int i = 0; i < n; i++) send_byte(frame_buf[i]);
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_byte($urandom_range(0, 2) == 0 ?
                              HDR_FIRST : 8'($urandom_range(0, 255)));
            end
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while good frames keep
    // coming back to back, so the block runs out of room and stalls its input.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(negedge i_clk);
        rx_hold_left = 300;
        for (int f = 0; f < 2; f++) begin
            fill_random_payload();
            send_frame(f[0] ? TYPE_T : TYPE_R, 8'h00);
        end
        wait_drained();
    endtask

    initial begin
        reset_parser_model();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        test_good_frames();
        test_bad_header();
        test_bad_type();
        test_bad_checksum();
        wait_drained();

        test_backpressure();

        test_random_traffic(20, 79, 1);
        test_random_traffic(79, 20, 1);
        test_random_traffic(0, 0, 1);

        repeat (TAIL_CYC) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
